FILE: hw/rtl/lrc_ltp_pkg.sv
// Shared types and constants of the LRC line timestamp parser.
package lrc_ltp_pkg;

	// Default longest line content, in bytes
	localparam int LINE_LIMIT_DEF = 95;

	// Width of the text offset field
	localparam int TEXT_W = 7;

	// Characters the parser looks for
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_BOM0   = 8'hEF;
	localparam logic [7:0] CH_BOM1   = 8'hBB;
	localparam logic [7:0] CH_BOM2   = 8'hBF;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_DIG0   = 8'h30;
	localparam logic [7:0] CH_DIG9   = 8'h39;

	// Time scaling
	localparam logic [31:0] MS_PER_MIN  = 32'd60000;
	localparam logic [31:0] MS_PER_SEC  = 32'd1000;
	localparam int          FRAC_DIGITS = 3;

	// One input word: a line byte and its end flag
	typedef struct packed {
		logic [7:0] line_byte;
		logic       line_end;
	} src_word_t;

	// One result word, given at the end of each line
	typedef struct packed {
		logic              tag_valid;
		logic [31:0]       time_ms;
		logic [TEXT_W-1:0] text_start;
		logic              text_is_empty;
	} res_word_t;

endpackage

FILE: hw/rtl/lrc_ltp_core.sv
// Byte-serial parse state of the LRC line timestamp parser.
module lrc_ltp_core #(
	parameter int LINE_LIMIT = lrc_ltp_pkg::LINE_LIMIT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  lrc_ltp_pkg::src_word_t word,
	output lrc_ltp_pkg::res_word_t result
);
	import lrc_ltp_pkg::*;

	localparam int POS_W = $clog2(LINE_LIMIT + 1);

	typedef enum logic [4:0] {
		PH_START     = 5'd0,
		PH_BOM1      = 5'd1,
		PH_BOM2      = 5'd2,
		PH_AFTER_BOM = 5'd3,
		PH_OPEN      = 5'd4,
		PH_MIN       = 5'd5,
		PH_SEC       = 5'd6,
		PH_FRAC      = 5'd7,
		PH_TAGS      = 5'd8,
		PH_SPACES    = 5'd9,
		PH_QUOTE     = 5'd10,
		PH_X_MIN1    = 5'd11,
		PH_X_MIN     = 5'd12,
		PH_X_SEC1    = 5'd13,
		PH_X_SEC     = 5'd14,
		PH_X_FRAC    = 5'd15,
		PH_DONE      = 5'd16,
		PH_FAIL      = 5'd17
	} phase_t;

	// Scale the fraction to milliseconds by its digit count
	function automatic logic [31:0] frac_ms(input logic [9:0] acc, input logic [1:0] cnt);
		logic [31:0] v;
		begin
			case (cnt)
				2'd0:    v = 32'd0;
				2'd1:    v = 32'(acc) * 32'd100;
				2'd2:    v = 32'(acc) * 32'd10;
				default: v = 32'(acc);
			endcase
			return v;
		end
	endfunction

	phase_t            ph_q, n_ph, e_ph;
	logic [POS_W-1:0]  pos_q, n_pos;
	logic [31:0]       min_ms_q, n_min_ms;
	logic [31:0]       sec_ms_q, n_sec_ms;
	logic [9:0]        facc_q, n_facc;
	logic [1:0]        fcnt_q, n_fcnt;
	logic [31:0]       first_q, n_first;
	logic [POS_W-1:0]  xstart_q, n_xstart;
	logic [POS_W-1:0]  toff_q, n_toff, e_toff;
	logic              tfound_q, n_tfound, e_tfound;

	logic [7:0]        b;
	logic              is_dig;
	logic [3:0]        dig;
	logic              active;
	logic [31:0]       min_ms_mac, sec_ms_mac, close_time;
	logic [9:0]        facc_mac;
	logic [POS_W-1:0]  start_pos;

	assign b      = word.line_byte;
	assign is_dig = (b >= CH_DIG0) && (b <= CH_DIG9);
	assign dig    = b[3:0];
	assign active = (ph_q != PH_DONE) && (ph_q != PH_FAIL) && (pos_q < POS_W'(LINE_LIMIT));

	// Accumulate minutes and seconds directly in milliseconds
	assign min_ms_mac = (min_ms_q << 3) + (min_ms_q << 1) + 32'(dig) * MS_PER_MIN;
	assign sec_ms_mac = (sec_ms_q << 3) + (sec_ms_q << 1) + 32'(dig) * MS_PER_SEC;
	assign facc_mac   = (facc_q << 3) + (facc_q << 1) + 10'(dig);
	assign close_time = min_ms_q + sec_ms_q + frac_ms(facc_q, fcnt_q);

	// Advance the parse by one byte, then close the line if it ends here
	always_comb begin
		n_ph     = ph_q;
		n_pos    = pos_q;
		n_min_ms = min_ms_q;
		n_sec_ms = sec_ms_q;
		n_facc   = facc_q;
		n_fcnt   = fcnt_q;
		n_first  = first_q;
		n_xstart = xstart_q;
		n_toff   = toff_q;
		n_tfound = tfound_q;

		if (active) begin
			if (b == CH_NUL) begin
				// A zero byte ends the content
				if (ph_q <= PH_FRAC) begin
					n_ph = PH_FAIL;
				end else if (ph_q >= PH_X_MIN1 && ph_q <= PH_X_FRAC) begin
					n_ph     = PH_DONE;
					n_toff   = xstart_q;
					n_tfound = 1'b1;
				end else begin
					n_ph = PH_DONE;
				end
			end else begin
				case (ph_q)
					PH_START: begin
						if (b == CH_BOM0) n_ph = PH_BOM1;
						else if (b == CH_QUOTE) n_ph = PH_OPEN;
						else if (b == CH_LBRACK) n_ph = PH_MIN;
						else n_ph = PH_FAIL;
					end
					PH_BOM1: begin
						n_ph = (b == CH_BOM1) ? PH_BOM2 : PH_FAIL;
					end
					PH_BOM2: begin
						n_ph = (b == CH_BOM2) ? PH_AFTER_BOM : PH_FAIL;
					end
					PH_AFTER_BOM: begin
						if (b == CH_QUOTE) n_ph = PH_OPEN;
						else if (b == CH_LBRACK) n_ph = PH_MIN;
						else n_ph = PH_FAIL;
					end
					PH_OPEN: begin
						n_ph = (b == CH_LBRACK) ? PH_MIN : PH_FAIL;
					end
					PH_MIN: begin
						if (is_dig) n_min_ms = min_ms_mac;
						else if (b == CH_COLON) n_ph = PH_SEC;
						else n_ph = PH_FAIL;
					end
					PH_SEC: begin
						if (is_dig) begin
							n_sec_ms = sec_ms_mac;
						end else if (b == CH_DOT) begin
							n_ph = PH_FRAC;
						end else if (b == CH_RBRACK) begin
							n_first = close_time;
							n_ph    = PH_TAGS;
						end else begin
							n_ph = PH_FAIL;
						end
					end
					PH_FRAC: begin
						if (is_dig && fcnt_q < 2'(FRAC_DIGITS)) begin
							n_facc = facc_mac;
							n_fcnt = fcnt_q + 2'd1;
						end else if (b == CH_RBRACK) begin
							n_first = close_time;
							n_ph    = PH_TAGS;
						end else begin
							n_ph = PH_FAIL;
						end
					end
					PH_TAGS, PH_SPACES: begin
						if (ph_q == PH_TAGS && b == CH_LBRACK) begin
							n_xstart = pos_q;
							n_ph     = PH_X_MIN1;
						end else if (b == CH_QUOTE) begin
							n_ph = PH_QUOTE;
						end else if (b == CH_SPACE) begin
							n_ph = PH_SPACES;
						end else begin
							n_ph     = PH_DONE;
							n_toff   = pos_q;
							n_tfound = 1'b1;
						end
					end
					PH_QUOTE: begin
						// The quote was not alone: text starts at it
						n_ph     = PH_DONE;
						n_toff   = pos_q - POS_W'(1);
						n_tfound = 1'b1;
					end
					PH_X_MIN1, PH_X_SEC1: begin
						if (is_dig) begin
							n_ph = (ph_q == PH_X_MIN1) ? PH_X_MIN : PH_X_SEC;
						end else begin
							n_ph     = PH_DONE;
							n_toff   = xstart_q;
							n_tfound = 1'b1;
						end
					end
					PH_X_MIN: begin
						if (b == CH_COLON) begin
							n_ph = PH_X_SEC1;
						end else if (!is_dig) begin
							n_ph     = PH_DONE;
							n_toff   = xstart_q;
							n_tfound = 1'b1;
						end
					end
					PH_X_SEC: begin
						if (b == CH_DOT) begin
							n_ph = PH_X_FRAC;
						end else if (b == CH_RBRACK) begin
							n_ph = PH_TAGS;
						end else if (!is_dig) begin
							n_ph     = PH_DONE;
							n_toff   = xstart_q;
							n_tfound = 1'b1;
						end
					end
					PH_X_FRAC: begin
						if (b == CH_RBRACK) begin
							n_ph = PH_TAGS;
						end else if (!is_dig) begin
							n_ph     = PH_DONE;
							n_toff   = xstart_q;
							n_tfound = 1'b1;
						end
					end
					default: begin
						n_ph = ph_q;
					end
				endcase
				if (n_ph != PH_DONE) begin
					n_pos = pos_q + POS_W'(1);
				end
			end
		end

		// Close the content at the line end
		e_ph     = n_ph;
		e_toff   = n_toff;
		e_tfound = n_tfound;
		if (n_ph <= PH_FRAC) begin
			e_ph = PH_FAIL;
		end else if (n_ph >= PH_X_MIN1 && n_ph <= PH_X_FRAC) begin
			e_ph     = PH_DONE;
			e_toff   = n_xstart;
			e_tfound = 1'b1;
		end

		start_pos = e_tfound ? e_toff : n_pos;

		if (e_ph == PH_FAIL) begin
			result = '0;
		end else begin
			result.tag_valid     = 1'b1;
			result.time_ms       = n_first;
			result.text_start    = TEXT_W'(start_pos);
			result.text_is_empty = !e_tfound;
		end
	end

	// Hold parse state; return to line start after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q     <= PH_START;
			pos_q    <= '0;
			min_ms_q <= '0;
			sec_ms_q <= '0;
			facc_q   <= '0;
			fcnt_q   <= '0;
			first_q  <= '0;
			xstart_q <= '0;
			toff_q   <= '0;
			tfound_q <= 1'b0;
		end else if (step) begin
			if (word.line_end) begin
				ph_q     <= PH_START;
				pos_q    <= '0;
				min_ms_q <= '0;
				sec_ms_q <= '0;
				facc_q   <= '0;
				fcnt_q   <= '0;
				first_q  <= '0;
				xstart_q <= '0;
				toff_q   <= '0;
				tfound_q <= 1'b0;
			end else begin
				ph_q     <= n_ph;
				pos_q    <= n_pos;
				min_ms_q <= n_min_ms;
				sec_ms_q <= n_sec_ms;
				facc_q   <= n_facc;
				fcnt_q   <= n_fcnt;
				first_q  <= n_first;
				xstart_q <= n_xstart;
				toff_q   <= n_toff;
				tfound_q <= n_tfound;
			end
		end
	end

endmodule

FILE: hw/rtl/lrc_line_timestamp_parser.sv
// Top level of the LRC line timestamp parser: word handshakes and staging registers.
//
// Feed the bytes of one lyric line, one word per cycle, with line_end set on the
// last byte. The block takes a new byte every cycle while src_stall is low, back to
// back, with no gap between lines. Each byte is held in the input register and is
// then parsed into the line state; the result word for a line is loaded into the
// output register at the edge where its last byte leaves the input register, and
// is held there with res_valid set until it is taken. The output register lets
// the next line's bytes keep flowing while a result waits; input stalls only
// when the last byte of a line finds the output register still full and
// stalled. Lines longer than LINE_LIMIT bytes are cut at that limit.
module lrc_line_timestamp_parser #(
	parameter int LINE_LIMIT = lrc_ltp_pkg::LINE_LIMIT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   src_valid,
	output logic                   src_stall,
	input  lrc_ltp_pkg::src_word_t src_word,
	output logic                   res_valid,
	input  logic                   res_stall,
	output lrc_ltp_pkg::res_word_t res_word
);
	import lrc_ltp_pkg::*;

	src_word_t src_s1;
	logic      valid_s1;
	logic      res_valid_q;
	res_word_t res_word_q;
	res_word_t core_res;
	logic      out_free;
	logic      go_s1;
	logic      take;

	// A byte moves on unless it ends a line and the result slot is busy
	assign out_free  = !res_valid_q || !res_stall;
	assign go_s1     = valid_s1 && (!src_s1.line_end || out_free);
	assign src_stall = valid_s1 && !go_s1;
	assign take      = src_valid && !src_stall;

	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

	lrc_ltp_core #(
		.LINE_LIMIT(LINE_LIMIT)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (go_s1),
		.word  (src_s1),
		.result(core_res)
	);

	// Hold the input word until the parser takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			src_s1 <= src_word;
		end
	end

	// Load the result word at the line end; drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (go_s1 && src_s1.line_end) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && src_s1.line_end) begin
			res_word_q <= core_res;
		end
	end

endmodule
